FILE: hdl/spb_pkg.sv
// Shared constants, transaction types and control structs of the binned string store.
package spb_pkg;

  localparam int BIN_BYTES_DEF = 4096;
  localparam int NUM_BINS_DEF  = 16;

  localparam int HANDLE_W = 17;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 12;
  localparam int COUNT_W  = 16;
  localparam int BYTES_W  = 17;
  localparam int STATUS_W = 2;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

  typedef struct packed {
    logic                cmd;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
    logic [LEN_W-1:0]    str_length;
    logic [HANDLE_W-1:0] handle;
  } in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] result_handle;
    logic [BYTE_W-1:0]   read_byte;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  string_count;
    logic [BYTES_W-1:0]  bytes_used;
  } out_t;

  typedef struct packed {
    logic latch_in;
    logic open_str;
    logic calc_base;
    logic store_byte;
    logic finish;
    logic div_step;
    logic rd_addr;
    logic rd_check;
  } cmd_t;

  typedef struct packed {
    logic cmd_read;
    logic in_string;
    logic len_zero;
    logic last;
  } sts_t;

endpackage

FILE: hdl/spb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/spb_datapath.sv
// Datapath: bin bookkeeping, byte and fill memories, handle split, result registers.
module spb_datapath #(
  parameter int BIN_BYTES = spb_pkg::BIN_BYTES_DEF,
  parameter int NUM_BINS  = spb_pkg::NUM_BINS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spb_pkg::in_t  in_i,
  input  spb_pkg::cmd_t cmd_i,
  output spb_pkg::sts_t sts_o,
  output spb_pkg::out_t result_o
);

  localparam int HW     = spb_pkg::HANDLE_W;
  localparam int LW     = spb_pkg::LEN_W;
  localparam int FILL_W = $clog2(BIN_BYTES + 1);
  localparam int RW     = $clog2(BIN_BYTES) + 1;
  localparam int BO_W   = $clog2(NUM_BINS + 1);
  localparam int BI_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int STORE  = BIN_BYTES * NUM_BINS;
  localparam int AW     = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int SW     = FILL_W + LW + 1;
  localparam int PW     = BO_W + FILL_W + 1;
  localparam int RSH    = HW + $clog2(BIN_BYTES);
  localparam int RCP_W  = HW + 1;
  localparam int PRD_W  = HW + RCP_W;
  // ceil(2^RSH / BIN_BYTES): exact quotient for every HW-bit handle
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RSH) + 64'(BIN_BYTES) - 64'd1) / 64'(BIN_BYTES));

  // latched item
  logic [spb_pkg::BYTE_W-1:0] data_q;
  logic                       last_q;
  logic [LW-1:0]              len_q;

  // string bookkeeping
  logic                          in_string_q, in_string_d;
  logic [BO_W-1:0]               bins_open_q, bins_open_d;
  logic [FILL_W-1:0]             cur_fill_q, cur_fill_d;
  logic [spb_pkg::COUNT_W-1:0]   strings_q, strings_d;
  logic [spb_pkg::BYTES_W-1:0]   total_q, total_d;
  logic [LW-1:0]                 count_q, count_d;
  logic [LW-1:0]                 plen_q, plen_d;
  logic [spb_pkg::STATUS_W-1:0]  perr_q, perr_d;
  logic [FILL_W-1:0]             poff_q, poff_d;
  logic [AW-1:0]                 wr_addr_q, wr_addr_d;
  logic [HW-1:0]                 phandle_q, phandle_d;

  // handle decode
  logic [HW-1:0]     hq_q, hq_d;
  logic [HW-1:0]     bin_q, bin_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic              bin_ok_q, bin_ok_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;

  // result
  logic [HW-1:0]                res_handle_q, res_handle_d;
  logic [spb_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                         res_sel_q, res_sel_d;

  // memory ports
  logic                       bwe;
  logic [AW-1:0]              bwaddr;
  logic [spb_pkg::BYTE_W-1:0] bwdata;
  logic                       bre;
  logic [spb_pkg::BYTE_W-1:0] brdata;
  logic                       fwe;
  logic [BI_W-1:0]            fwaddr;
  logic [FILL_W-1:0]          fwdata;
  logic                       fre;
  logic [BI_W-1:0]            fraddr;
  logic [FILL_W-1:0]          frdata;

  logic [SW-1:0] need_sum;
  logic          too_long, need_new, pool_full, has_room;
  logic [PW-1:0] base_w;
  logic [PRD_W-1:0] recip_prod;
  logic [HW-1:0] bin_base;
  logic [BO_W-1:0] rbin;
  logic          rd_ok;

  assign need_sum  = SW'(cur_fill_q) + SW'(len_q) + SW'(1);
  assign too_long  = (SW'(len_q) + SW'(1)) > SW'(BIN_BYTES);
  assign need_new  = (bins_open_q == '0) || (need_sum > SW'(BIN_BYTES));
  assign pool_full = bins_open_q >= BO_W'(NUM_BINS);
  assign has_room  = count_q < plen_q;

  assign base_w = PW'(bins_open_q - BO_W'(1)) * PW'(BIN_BYTES) + PW'(poff_q);

  assign recip_prod = PRD_W'(hq_q) * PRD_W'(RECIP);
  assign bin_base   = bin_q * HW'(BIN_BYTES);

  assign rbin    = bin_q[BO_W-1:0];
  assign rd_ok   = bin_ok_q && (SW'(rem_q) < SW'(frdata));

  always_comb begin
    in_string_d  = in_string_q;
    bins_open_d  = bins_open_q;
    cur_fill_d   = cur_fill_q;
    strings_d    = strings_q;
    total_d      = total_q;
    count_d      = count_q;
    plen_d       = plen_q;
    perr_d       = perr_q;
    poff_d       = poff_q;
    wr_addr_d    = wr_addr_q;
    phandle_d    = phandle_q;
    hq_d         = hq_q;
    bin_d        = bin_q;
    rem_d        = rem_q;
    bin_ok_d     = bin_ok_q;
    rd_addr_d    = rd_addr_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    res_sel_d    = res_sel_q;
    bwe    = 1'b0;
    bwaddr = wr_addr_q;
    bwdata = data_q;
    bre    = 1'b0;
    fwe    = 1'b0;
    fwaddr = BI_W'(bins_open_q - BO_W'(1));
    fwdata = '0;
    fre    = 1'b0;
    fraddr = BI_W'(rbin - BO_W'(1));

    if (cmd_i.latch_in) begin
      hq_d = in_i.handle;
    end

    if (cmd_i.open_str) begin
      in_string_d = 1'b1;
      plen_d      = len_q;
      count_d     = '0;
      perr_d      = spb_pkg::ST_OK;
      poff_d      = cur_fill_q;
      if (len_q != '0) begin
        if (too_long) begin
          perr_d = spb_pkg::ST_FULL;
        end else if (need_new) begin
          if (pool_full) begin
            perr_d = spb_pkg::ST_FULL;
          end else begin
            bins_open_d = bins_open_q + BO_W'(1);
            cur_fill_d  = '0;
            poff_d      = '0;
            fwe         = 1'b1;
            fwaddr      = BI_W'(bins_open_q);
            fwdata      = '0;
          end
        end
      end
    end

    if (cmd_i.calc_base) begin
      wr_addr_d = AW'(base_w);
      phandle_d = HW'(base_w + PW'(BIN_BYTES));
    end

    if (cmd_i.store_byte) begin
      if (has_room) begin
        if (perr_q != spb_pkg::ST_FULL) begin
          bwe       = 1'b1;
          wr_addr_d = wr_addr_q + AW'(1);
        end
        count_d = count_q + LW'(1);
      end else if (perr_q != spb_pkg::ST_FULL) begin
        perr_d = spb_pkg::ST_MISMATCH;
      end
    end

    if (cmd_i.finish) begin
      in_string_d  = 1'b0;
      res_sel_d    = 1'b0;
      res_handle_d = '0;
      if (perr_q == spb_pkg::ST_FULL) begin
        res_status_d = spb_pkg::ST_FULL;
      end else if (plen_q == '0) begin
        res_status_d = perr_q;
      end else begin
        res_status_d = (count_q != plen_q) ? spb_pkg::ST_MISMATCH : perr_q;
        res_handle_d = phandle_q;
        bwe          = 1'b1;
        bwdata       = spb_pkg::TERMINATOR;
        cur_fill_d   = FILL_W'(SW'(cur_fill_q) + SW'(count_q) + SW'(1));
        fwe          = 1'b1;
        fwdata       = cur_fill_d;
        total_d      = total_q + spb_pkg::BYTES_W'(count_q) + spb_pkg::BYTES_W'(1);
        strings_d    = strings_q + spb_pkg::COUNT_W'(1);
      end
    end

    if (cmd_i.div_step) begin
      bin_d = HW'(recip_prod >> RSH);
    end

    if (cmd_i.rd_addr) begin
      bin_ok_d  = (bin_q != '0) && (bin_q <= HW'(bins_open_q));
      rd_addr_d = AW'(hq_q - HW'(BIN_BYTES));
      rem_d     = RW'(hq_q - bin_base);
      fre       = 1'b1;
    end

    if (cmd_i.rd_check) begin
      bre          = rd_ok;
      bwaddr       = wr_addr_q;
      res_handle_d = '0;
      res_sel_d    = rd_ok;
      res_status_d = rd_ok ? spb_pkg::ST_OK : spb_pkg::ST_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      bins_open_q <= '0;
      cur_fill_q  <= '0;
      strings_q   <= '0;
      total_q     <= '0;
      count_q     <= '0;
      plen_q      <= '0;
      perr_q      <= spb_pkg::ST_OK;
      phandle_q   <= '0;
    end else begin
      in_string_q <= in_string_d;
      bins_open_q <= bins_open_d;
      cur_fill_q  <= cur_fill_d;
      strings_q   <= strings_d;
      total_q     <= total_d;
      count_q     <= count_d;
      plen_q      <= plen_d;
      perr_q      <= perr_d;
      phandle_q   <= phandle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      data_q <= in_i.data_byte;
      last_q <= in_i.last;
      len_q  <= in_i.str_length;
    end
    poff_q       <= poff_d;
    wr_addr_q    <= wr_addr_d;
    hq_q         <= hq_d;
    bin_q        <= bin_d;
    rem_q        <= rem_d;
    bin_ok_q     <= bin_ok_d;
    rd_addr_q    <= rd_addr_d;
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
    res_sel_q    <= res_sel_d;
  end

  spb_ram #(
    .WIDTH (spb_pkg::BYTE_W),
    .DEPTH (STORE),
    .AW    (AW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (bwe),
    .waddr_i (bwaddr),
    .wdata_i (bwdata),
    .re_i    (bre),
    .raddr_i (rd_addr_q),
    .rdata_o (brdata)
  );

  spb_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_BINS),
    .AW    (BI_W)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fwe),
    .waddr_i (fwaddr),
    .wdata_i (fwdata),
    .re_i    (fre),
    .raddr_i (fraddr),
    .rdata_o (frdata)
  );

  assign sts_o.cmd_read  = in_i.cmd == spb_pkg::CMD_READ;
  assign sts_o.in_string = in_string_q;
  assign sts_o.len_zero  = len_q == '0;
  assign sts_o.last      = last_q;

  assign result_o.result_handle = res_handle_q;
  assign result_o.read_byte     = res_sel_q ? brdata : '0;
  assign result_o.status        = res_status_q;
  assign result_o.string_count  = strings_q;
  assign result_o.bytes_used    = total_q;

endmodule

FILE: hdl/spb_ctrl.sv
// Controller state machine sequencing append and read transactions.
module spb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spb_pkg::sts_t sts_i,
  output spb_pkg::cmd_t cmd_o,
  output logic          result_valid_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_OPEN = 9'b000000010,
    S_BASE = 9'b000000100,
    S_BYTE = 9'b000001000,
    S_FIN  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_RADR = 9'b001000000,
    S_RCHK = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch_in = 1'b1;
          if (sts_i.cmd_read) begin
            state_d = S_DIV;
          end else if (sts_i.in_string) begin
            state_d = S_BYTE;
          end else begin
            state_d = S_OPEN;
          end
        end
      end
      S_OPEN: begin
        cmd_o.open_str = 1'b1;
        if (!sts_i.len_zero) begin
          state_d = S_BASE;
        end else if (sts_i.last) begin
          state_d = S_FIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BASE: begin
        cmd_o.calc_base = 1'b1;
        state_d = S_BYTE;
      end
      S_BYTE: begin
        cmd_o.store_byte = 1'b1;
        state_d = sts_i.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_EMIT;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d = S_RADR;
      end
      S_RADR: begin
        cmd_o.rd_addr = 1'b1;
        state_d = S_RCHK;
      end
      S_RCHK: begin
        cmd_o.rd_check = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = state_q == S_EMIT;

endmodule

FILE: hdl/string_pool_binned_store_top.sv
// Top level of the binned string store: controller plus datapath.
//
//  channel   ports                        transaction taken when
//  --------  ---------------------------  ------------------------------
//  item in   start, busy, in_i            rising edge with start & !busy
//  result    result_valid_o, result_o     rising edge with result_valid_o
//
// An append of a byte inside a string passes the byte-store state only; the
// first byte of a string adds the bin check and address setup before it, and
// a last byte adds the terminator write and the result state. A read first
// splits the handle into bin and offset by reciprocal multiplication, then
// does the fill and byte memory reads and ends in the result state.
// Reset is asynchronous, active low; the byte memory is not cleared.
// The result is held for one cycle only; there is no output stall.
module string_pool_binned_store_top #(
  parameter int BIN_BYTES = spb_pkg::BIN_BYTES_DEF,
  parameter int NUM_BINS  = spb_pkg::NUM_BINS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spb_pkg::in_t  in_i,
  output logic          result_valid_o,
  output spb_pkg::out_t result_o
);

  spb_pkg::cmd_t cmd;
  spb_pkg::sts_t sts;

  spb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  spb_datapath #(
    .BIN_BYTES (BIN_BYTES),
    .NUM_BINS  (NUM_BINS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule
